/* src/bfra_pkg.sv */
// shared types and codes of the best-fit region allocator
package bfra_pkg;

   // operation codes on the request channel
   localparam logic [2:0] FuncAlloc   = 3'd0;
   localparam logic [2:0] FuncRelease = 3'd1;
   localparam logic [2:0] FuncTick    = 3'd2;
   localparam logic [2:0] FuncCompact = 3'd3;
   localparam logic [2:0] FuncQuery   = 3'd4;

   // status codes on the response channel
   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusNoJob = 2'd1;
   localparam logic [1:0] StatusNoFit = 2'd2;
   localparam logic [1:0] StatusDup   = 2'd3;

   // memory size after reset
   localparam logic [16:0] TotalReset = 17'd65536;

   // one job table entry as stored in memory
   typedef struct packed {
      logic [15:0] ident;
      logic [16:0] base;
      logic [16:0] length;
      logic [15:0] time_left;
   } entry_type;

   // write side of the job table
   typedef struct packed {
      logic      en;
      entry_type data;
   } table_wr_type;

   // request payload
   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] job_id;
      logic [16:0] job_size;
      logic [15:0] job_duration;
      logic [15:0] time_step;
   } req_type;

   // response payload
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] placed_base;
      logic [16:0] best_hole_size;
      logic [16:0] free_units;
      logic [4:0]  finished_jobs;
      logic        any_jobs;
   } rsp_type;

endpackage

/* src/bfra_req_if.sv */
// request channel of the allocator
interface bfra_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [15:0] job_id;
   logic [16:0] job_size;
   logic [15:0] job_duration;
   logic [15:0] time_step;

   modport source (output valid, func, job_id, job_size, job_duration, time_step,
                   input ready);
   modport sink   (input valid, func, job_id, job_size, job_duration, time_step,
                   output ready);
endinterface

/* src/bfra_rsp_if.sv */
// response channel of the allocator
interface bfra_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] placed_base;
   logic [16:0] best_hole_size;
   logic [16:0] free_units;
   logic [4:0]  finished_jobs;
   logic        any_jobs;

   modport source (output valid, status, placed_base, best_hole_size, free_units,
                   finished_jobs, any_jobs, input ready);
   modport sink   (input valid, status, placed_base, best_hole_size, free_units,
                   finished_jobs, any_jobs, output ready);
endinterface

/* src/bfra_table.sv */
// job table memory, one write port and one registered read port
module bfra_table #(
   parameter int MAX_JOBS = 16,
   localparam int IW = $clog2(MAX_JOBS)
) (
   input  logic                   clock,
   input  logic [IW-1:0]          rd_addr,
   output bfra_pkg::entry_type    rd_data,
   input  logic [IW-1:0]          wr_addr,
   input  bfra_pkg::table_wr_type wr
);

   bfra_pkg::entry_type mem [MAX_JOBS];

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* src/bfra_seq.sv */
// operation sequencer: table scans, hole search, compaction and accounting
module bfra_seq #(
   parameter int MAX_JOBS  = 16,
   parameter int ADDR_BITS = 16,
   localparam int IW = $clog2(MAX_JOBS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [16:0]            csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bfra_pkg::req_type      req,
   output logic                   done,
   output bfra_pkg::rsp_type      result,
   input  logic                   slot_free,
   output logic [IW-1:0]          rd_addr,
   input  bfra_pkg::entry_type    rd_data,
   output logic [IW-1:0]          wr_addr,
   output bfra_pkg::table_wr_type wr
);

   localparam int CW = $clog2(MAX_JOBS + 1);
   localparam int OW = $clog2(MAX_JOBS + 2);
   localparam longint unsigned CapFull = 64'd1 << ADDR_BITS;
   localparam logic [16:0] Cap = (CapFull > 64'h1FFFF) ? 17'h1FFFF : 17'(CapFull);
   localparam logic [16:0] ResetEff =
      (bfra_pkg::TotalReset > Cap) ? Cap : bfra_pkg::TotalReset;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_FDEC, S_MIN, S_MEND, S_PEND, S_PGET, S_FIN, S_TICK, S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [OW-1:0]       o_ff, o_in;
   logic [MAX_JOBS-1:0] valid_ff, valid_in;
   logic [16:0]         free_ff, free_in;
   logic [16:0]         used_ff, used_in;
   logic [16:0]         eff_ff, eff_in;
   bfra_pkg::req_type   op_ff, op_in;
   logic [17:0]         thr_ff, thr_in;
   logic [17:0]         next_ff, next_in;
   logic                mfound_ff, mfound_in;
   logic [IW-1:0]       midx_ff, midx_in;
   bfra_pkg::entry_type ment_ff, ment_in;
   logic                hfound_ff, hfound_in;
   logic [16:0]         hbase_ff, hbase_in;
   logic [16:0]         hsize_ff, hsize_in;
   logic [CW-1:0]       fin_ff, fin_in;
   logic [1:0]          rstat_ff, rstat_in;
   logic [15:0]         rplace_ff, rplace_in;
   logic [16:0]         rhole_ff, rhole_in;

   logic [CW-1:0] dk;
   logic [IW-1:0] di;
   logic          dvalid;
   logic          scan_last;
   logic [IW-1:0] slot;
   logic          slot_ok;
   logic [IW-1:0] oe;

   // index of the entry whose read data arrives this cycle
   assign dk        = cnt_ff - CW'(1);
   assign di        = dk[IW-1:0];
   assign dvalid    = (cnt_ff != '0) && valid_ff[di];
   assign scan_last = (cnt_ff == CW'(MAX_JOBS));
   assign oe        = IW'(o_ff - OW'(1));
   assign req_ready = (state_ff == S_IDLE);
   assign done      = (state_ff == S_DONE) && slot_free;

   // lowest free table slot
   always_comb begin
      slot    = '0;
      slot_ok = 1'b0;
      for (int k = MAX_JOBS - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            slot    = IW'(k);
            slot_ok = 1'b1;
         end
      end
   end

   // response built from the final state of the operation
   always_comb begin
      result.status         = rstat_ff;
      result.placed_base    = rplace_ff;
      result.best_hole_size = rhole_ff;
      result.free_units     = free_ff;
      result.finished_jobs  = 5'(fin_ff);
      result.any_jobs       = |valid_ff;
   end

   // next-state logic
   always_comb begin
      logic [16:0] cfg_v;
      logic [16:0] cfg_e;
      logic [17:0] fsum;
      logic [17:0] nxt;
      logic [17:0] gap;
      logic [15:0] tl;
      bfra_pkg::entry_type we;

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      o_in      = o_ff;
      valid_in  = valid_ff;
      free_in   = free_ff;
      used_in   = used_ff;
      eff_in    = eff_ff;
      op_in     = op_ff;
      thr_in    = thr_ff;
      next_in   = next_ff;
      mfound_in = mfound_ff;
      midx_in   = midx_ff;
      ment_in   = ment_ff;
      hfound_in = hfound_ff;
      hbase_in  = hbase_ff;
      hsize_in  = hsize_ff;
      fin_in    = fin_ff;
      rstat_in  = rstat_ff;
      rplace_in = rplace_ff;
      rhole_in  = rhole_ff;
      rd_addr   = (cnt_ff < CW'(MAX_JOBS)) ? cnt_ff[IW-1:0] : '0;
      wr_addr   = '0;
      wr        = '0;
      cfg_v     = csr_wr_data;
      cfg_e     = (cfg_v == '0) ? 17'd1 : ((cfg_v > Cap) ? Cap : cfg_v);
      fsum      = '0;
      nxt       = '0;
      gap       = '0;
      tl        = '0;
      we        = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            // register write: recompute free memory from live lengths
            if (csr_wr_en) begin
               eff_in  = cfg_e;
               free_in = (cfg_e > used_ff) ? cfg_e - used_ff : '0;
            end
            if (req_valid) begin
               op_in     = req;
               cnt_in    = '0;
               o_in      = '0;
               thr_in    = '0;
               next_in   = '0;
               mfound_in = 1'b0;
               hfound_in = 1'b0;
               fin_in    = '0;
               rstat_in  = bfra_pkg::StatusOk;
               rplace_in = '0;
               rhole_in  = '0;
               priority case (req.func)
                  bfra_pkg::FuncAlloc, bfra_pkg::FuncRelease: state_in = S_FIND;
                  bfra_pkg::FuncTick:                         state_in = S_TICK;
                  bfra_pkg::FuncCompact, bfra_pkg::FuncQuery: state_in = S_MIN;
                  default:                                    state_in = S_DONE;
               endcase
            end
         end

         // look up the identifier
         S_FIND: begin
            if (dvalid && !mfound_ff && rd_data.ident == op_ff.job_id) begin
               mfound_in = 1'b1;
               midx_in   = di;
               ment_in   = rd_data;
            end
            cnt_in = cnt_ff + CW'(1);
            if (scan_last) begin
               state_in = S_FDEC;
            end
         end

         S_FDEC: begin
            if (op_ff.func == bfra_pkg::FuncAlloc) begin
               if (mfound_ff) begin
                  rstat_in = bfra_pkg::StatusDup;
                  state_in = S_DONE;
               end else if (op_ff.job_size == '0) begin
                  state_in = S_FIN;
               end else begin
                  cnt_in    = '0;
                  o_in      = '0;
                  thr_in    = '0;
                  mfound_in = 1'b0;
                  state_in  = S_MIN;
               end
            end else begin
               if (mfound_ff) begin
                  valid_in[midx_ff] = 1'b0;
                  fsum    = {1'b0, free_ff} + {1'b0, ment_ff.length};
                  free_in = fsum[17] ? 17'h1FFFF : fsum[16:0];
                  used_in = used_ff - ment_ff.length;
               end else begin
                  rstat_in = bfra_pkg::StatusNoJob;
               end
               state_in = S_DONE;
            end
         end

         // lowest live base at or above the threshold
         S_MIN: begin
            if (dvalid && {1'b0, rd_data.base} >= thr_ff &&
                (!mfound_ff || rd_data.base < ment_ff.base)) begin
               mfound_in = 1'b1;
               midx_in   = di;
               ment_in   = rd_data;
            end
            cnt_in = cnt_ff + CW'(1);
            if (scan_last) begin
               state_in = S_MEND;
            end
         end

         S_MEND: begin
            if (op_ff.func == bfra_pkg::FuncCompact) begin
               // slide the next job in address order down
               if (mfound_ff) begin
                  we        = ment_ff;
                  we.base   = next_ff[16:0];
                  wr.en     = 1'b1;
                  wr.data   = we;
                  wr_addr   = midx_ff;
                  next_in   = next_ff + {1'b0, ment_ff.length};
                  thr_in    = {1'b0, ment_ff.base} + 18'd1;
                  cnt_in    = '0;
                  mfound_in = 1'b0;
                  state_in  = S_MIN;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               // hole from the candidate start up to the next job or the top
               nxt = mfound_ff ? {1'b0, ment_ff.base} : {1'b0, eff_ff};
               if (nxt > thr_ff) begin
                  gap = nxt - thr_ff;
                  if (gap >= {1'b0, op_ff.job_size} &&
                      (!hfound_ff || gap[16:0] < hsize_ff ||
                       (gap[16:0] == hsize_ff && thr_ff[16:0] < hbase_ff))) begin
                     hfound_in = 1'b1;
                     hbase_in  = thr_ff[16:0];
                     hsize_in  = gap[16:0];
                  end
               end
               o_in     = o_ff + OW'(1);
               state_in = S_PEND;
            end
         end

         // next candidate start: the end of a live job
         S_PEND: begin
            if (o_ff == OW'(MAX_JOBS + 1)) begin
               state_in = S_FIN;
            end else if (valid_ff[oe]) begin
               rd_addr  = oe;
               state_in = S_PGET;
            end else begin
               o_in = o_ff + OW'(1);
            end
         end

         S_PGET: begin
            thr_in    = {1'b0, rd_data.base} + {1'b0, rd_data.length};
            cnt_in    = '0;
            mfound_in = 1'b0;
            state_in  = S_MIN;
         end

         // place the job or report the hole
         S_FIN: begin
            rhole_in = hfound_ff ? hsize_ff : '0;
            if (op_ff.func == bfra_pkg::FuncAlloc) begin
               if (!hfound_ff || !slot_ok) begin
                  rstat_in = bfra_pkg::StatusNoFit;
               end else begin
                  we.ident     = op_ff.job_id;
                  we.base      = hbase_ff;
                  we.length    = op_ff.job_size;
                  we.time_left = op_ff.job_duration;
                  wr.en        = 1'b1;
                  wr.data      = we;
                  wr_addr      = slot;
                  valid_in[slot] = 1'b1;
                  free_in   = (free_ff > op_ff.job_size) ? free_ff - op_ff.job_size : '0;
                  used_in   = used_ff + op_ff.job_size;
                  rplace_in = hbase_ff[15:0];
               end
            end
            state_in = S_DONE;
         end

         // age every live job, retire the expired ones
         S_TICK: begin
            if (dvalid) begin
               tl = (rd_data.time_left > op_ff.time_step)
                    ? rd_data.time_left - op_ff.time_step : '0;
               we.time_left = tl;
               wr.en   = 1'b1;
               wr.data = we;
               wr_addr = di;
               if (tl == '0) begin
                  valid_in[di] = 1'b0;
                  fsum    = {1'b0, free_ff} + {1'b0, rd_data.length};
                  free_in = fsum[17] ? 17'h1FFFF : fsum[16:0];
                  used_in = used_ff - rd_data.length;
                  fin_in  = fin_ff + CW'(1);
               end
            end
            cnt_in = cnt_ff + CW'(1);
            if (scan_last) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state and registered results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         o_ff     <= '0;
         valid_ff <= '0;
         free_ff  <= ResetEff;
         used_ff  <= '0;
         eff_ff   <= ResetEff;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         o_ff     <= o_in;
         valid_ff <= valid_in;
         free_ff  <= free_in;
         used_ff  <= used_in;
         eff_ff   <= eff_in;
      end
      op_ff     <= op_in;
      thr_ff    <= thr_in;
      next_ff   <= next_in;
      mfound_ff <= mfound_in;
      midx_ff   <= midx_in;
      ment_ff   <= ment_in;
      hfound_ff <= hfound_in;
      hbase_ff  <= hbase_in;
      hsize_ff  <= hsize_in;
      fin_ff    <= fin_in;
      rstat_ff  <= rstat_in;
      rplace_ff <= rplace_in;
      rhole_ff  <= rhole_in;
   end

endmodule

/* src/best_fit_region_allocator.sv */
// Best-fit region allocator: job table in memory, five operations.
// Requests arrive on req_chan (valid/ready); one transfer carries func, job_id,
// job_size, job_duration and time_step. Each request yields exactly one
// response transfer on rsp_chan with status, placed base, best-fit hole size,
// free units, finished job count and a live-job flag.
// One request is worked on at a time; req_chan.ready is high only when the
// sequencer is idle. Every table scan reads one entry per cycle from the
// job table. req_chan.ready rises in the same cycle as rsp_chan.valid.
// Results go to an output register, so the next request is taken while a
// response waits; the sequencer holds its next result until that register
// drains. csr_wr_en writes the memory size; write only while idle.
// Synchronous reset empties the table and sets the memory size to 65536,
// capped at 2**ADDR_BITS.
module best_fit_region_allocator #(
   parameter int MAX_JOBS  = 16,
   parameter int ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   bfra_req_if.sink    req_chan,
   bfra_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data
);

   localparam int IW = $clog2(MAX_JOBS);

   bfra_pkg::req_type      req;
   bfra_pkg::rsp_type      result;
   bfra_pkg::rsp_type      rsp_ff;
   bfra_pkg::entry_type    rd_data;
   bfra_pkg::table_wr_type wr;
   logic [IW-1:0]          rd_addr;
   logic [IW-1:0]          wr_addr;
   logic                   done;
   logic                   slot_free;
   logic                   rsp_valid_ff;

   // request payload
   always_comb begin
      req.func         = req_chan.func;
      req.job_id       = req_chan.job_id;
      req.job_size     = req_chan.job_size;
      req.job_duration = req_chan.job_duration;
      req.time_step    = req_chan.time_step;
   end

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   bfra_table #(.MAX_JOBS(MAX_JOBS)) u_table (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_addr (wr_addr),
      .wr      (wr)
   );

   bfra_seq #(.MAX_JOBS(MAX_JOBS), .ADDR_BITS(ADDR_BITS)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req         (req),
      .done        (done),
      .result      (result),
      .slot_free   (slot_free),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr_addr     (wr_addr),
      .wr          (wr)
   );

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.placed_base    = rsp_ff.placed_base;
   assign rsp_chan.best_hole_size = rsp_ff.best_hole_size;
   assign rsp_chan.free_units     = rsp_ff.free_units;
   assign rsp_chan.finished_jobs  = rsp_ff.finished_jobs;
   assign rsp_chan.any_jobs       = rsp_ff.any_jobs;

endmodule

/* src/bfra_checker.sv */
// port-level checks of the allocator, bound to the top level
module bfra_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  status,
   input logic [15:0] placed_base,
   input logic [16:0] best_hole_size,
   input logic [4:0]  finished_jobs
);

   // response held until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // no response straight out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a taken request leaves the block busy in the cycle after the transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // failed operations place nothing
   a_no_place: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != bfra_pkg::StatusOk |-> placed_base == '0)
      else $error("base reported on failed operation");

   // retired jobs only come from advance time, which reports no hole
   a_tick_hole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && finished_jobs != '0 |-> best_hole_size == '0)
      else $error("hole size reported with finished jobs");

endmodule

bind best_fit_region_allocator bfra_checker u_bfra_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .status         (rsp_chan.status),
   .placed_base    (rsp_chan.placed_base),
   .best_hole_size (rsp_chan.best_hole_size),
   .finished_jobs  (rsp_chan.finished_jobs)
);

/* dv/tb_best_fit_region_allocator.sv */
// self-checking testbench of the best-fit region allocator
module tb_best_fit_region_allocator;

   localparam int NumJobs       = 16;
   localparam int WatchdogLimit = 20000;
   localparam int SettleCycles  = 40;
   localparam int HoldCycles    = 600;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [16:0] csr_wr_data;

   bfra_req_if req_chan ();
   bfra_rsp_if rsp_chan ();

   best_fit_region_allocator #(.MAX_JOBS(NumJobs), .ADDR_BITS(16)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predicted job table and memory state
   logic        job_live [NumJobs];
   logic [15:0] job_ident [NumJobs];
   logic [16:0] job_base [NumJobs];
   logic [16:0] job_len [NumJobs];
   logic [15:0] job_left [NumJobs];
   logic [16:0] mem_size;
   logic [16:0] free_count;

   bfra_pkg::rsp_type pending_rsp_q[$];
   int      mismatches;
   int      tx_idle_pct;
   int      rx_stall_pct;
   bit      hold_req;
   int      hold_left;
   int      quiet_cycles;

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint usable_size();
      if (mem_size == 17'd0) return 1;
      if (mem_size > 17'd65536) return 65536;
      return mem_size;
   endfunction

   // live job slots in ascending base order
   function automatic int order_by_base(output int ord[NumJobs]);
      int n;
      int k;
      int j;
      n = 0;
      for (int i = 0; i < NumJobs; i++) begin
         ord[i] = 0;
         if (job_live[i]) begin
            ord[n] = i;
            n++;
         end
      end
      for (int i = 1; i < n; i++) begin
         k = ord[i];
         j = i - 1;
         while (j >= 0 && job_base[ord[j]] > job_base[k]) begin
            ord[j+1] = ord[j];
            j--;
         end
         ord[j+1] = k;
      end
      return n;
   endfunction

   // smallest hole of at least need units, lowest address on ties
   function automatic bit find_best_hole(input longint need, output longint hbase,
                                         output longint hsize);
      int     ord[NumJobs];
      int     n;
      longint prev;
      longint start;
      longint stop;
      bit     found;
      n = order_by_base(ord);
      prev = 0;
      found = 0;
      hbase = 0;
      hsize = 0;
      for (int i = 0; i <= n; i++) begin
         start = (i < n) ? longint'(job_base[ord[i]]) : usable_size();
         if (start > prev && start - prev >= need && (!found || start - prev < hsize)) begin
            found = 1;
            hbase = prev;
            hsize = start - prev;
         end
         if (i < n) begin
            stop = longint'(job_base[ord[i]]) + longint'(job_len[ord[i]]);
            if (stop > prev) prev = stop;
         end
      end
      return found;
   endfunction

   function automatic int slot_of(input logic [15:0] id);
      for (int i = 0; i < NumJobs; i++)
         if (job_live[i] && job_ident[i] == id) return i;
      return -1;
   endfunction

   function automatic void retire_job(input int i);
      longint sum;
      job_live[i] = 1'b0;
      sum = longint'(free_count) + longint'(job_len[i]);
      free_count = (sum > 17'h1FFFF) ? 17'h1FFFF : sum[16:0];
   endfunction

   function automatic void reset_allocation_model();
      for (int i = 0; i < NumJobs; i++) begin
         job_live[i] = 1'b0;
         job_ident[i] = '0;
         job_base[i] = '0;
         job_len[i] = '0;
         job_left[i] = '0;
      end
      mem_size = bfra_pkg::TotalReset;
      free_count = bfra_pkg::TotalReset;
   endfunction

   function automatic void resize_allocation_model(input logic [16:0] value);
      longint used;
      used = 0;
      mem_size = value;
      for (int i = 0; i < NumJobs; i++)
         if (job_live[i]) used += job_len[i];
      free_count = (usable_size() > used) ? 17'(usable_size() - used) : 17'd0;
   endfunction

   // expected response of one request, with the table updated
   function automatic bfra_pkg::rsp_type predict_allocation(input bfra_pkg::req_type op);
      bfra_pkg::rsp_type r;
      int      slot;
      int      ord[NumJobs];
      int      n;
      longint  hb;
      longint  hs;
      longint  next_base;
      r = '0;
      case (op.func)
         bfra_pkg::FuncAlloc: begin
            if (slot_of(op.job_id) >= 0) begin
               r.status = bfra_pkg::StatusDup;
            end else begin
               slot = -1;
               for (int i = NumJobs - 1; i >= 0; i--)
                  if (!job_live[i]) slot = i;
               if (op.job_size != 0 && find_best_hole(op.job_size, hb, hs))
                  r.best_hole_size = hs[16:0];
               if (op.job_size == 0 || r.best_hole_size == 0 || slot < 0) begin
                  r.status = bfra_pkg::StatusNoFit;
               end else begin
                  job_live[slot] = 1'b1;
                  job_ident[slot] = op.job_id;
                  job_base[slot] = hb[16:0];
                  job_len[slot] = op.job_size;
                  job_left[slot] = op.job_duration;
                  free_count = (free_count > op.job_size) ? free_count - op.job_size : 17'd0;
                  r.placed_base = hb[15:0];
               end
            end
         end
         bfra_pkg::FuncRelease: begin
            slot = slot_of(op.job_id);
            if (slot < 0) r.status = bfra_pkg::StatusNoJob;
            else retire_job(slot);
         end
         bfra_pkg::FuncTick: begin
            for (int i = 0; i < NumJobs; i++) begin
               if (job_live[i]) begin
                  job_left[i] = (job_left[i] > op.time_step) ? job_left[i] - op.time_step
                                                             : 16'd0;
                  if (job_left[i] == 0) begin
                     retire_job(i);
                     r.finished_jobs++;
                  end
               end
            end
         end
         bfra_pkg::FuncCompact: begin
            n = order_by_base(ord);
            next_base = 0;
            for (int i = 0; i < n; i++) begin
               job_base[ord[i]] = next_base[16:0];
               next_base += job_len[ord[i]];
            end
         end
         bfra_pkg::FuncQuery: begin
            if (find_best_hole(op.job_size, hb, hs)) r.best_hole_size = hs[16:0];
         end
         default: ;
      endcase
      r.free_units = free_count;
      for (int i = 0; i < NumJobs; i++)
         if (job_live[i]) r.any_jobs = 1'b1;
      return r;
   endfunction

   // offer one request, wait for its transfer, record the expected response
   task automatic send_op(input bfra_pkg::req_type op);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.func         <= op.func;
      req_chan.job_id       <= op.job_id;
      req_chan.job_size     <= op.job_size;
      req_chan.job_duration <= op.job_duration;
      req_chan.time_step    <= op.time_step;
      do @(posedge clock); while (!req_chan.ready);
      pending_rsp_q.push_back(predict_allocation(op));
   endtask

   task automatic send_fields(input logic [2:0] func, input logic [15:0] id,
                              input logic [16:0] size, input logic [15:0] dur,
                              input logic [15:0] step);
      bfra_pkg::req_type op;
      op.func = func;
      op.job_id = id;
      op.job_size = size;
      op.job_duration = dur;
      op.time_step = step;
      send_op(op);
   endtask

   // let every response arrive and the block settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_mem_size(input logic [16:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      resize_allocation_model(value);
   endtask

   // random request, mostly meaningful traffic over a small id pool
   function automatic bfra_pkg::req_type random_op();
      bfra_pkg::req_type op;
      int      pick;
      int      live[$];
      longint  cap;
      cap = usable_size() / 5;
      if (cap < 1) cap = 1;
      op.job_id = 16'($urandom_range(0, 23));
      pick = $urandom_range(99);
      if (pick < 20) begin
         op.job_id = 16'($urandom);
      end else if (pick < 45) begin
         for (int i = 0; i < NumJobs; i++)
            if (job_live[i]) live.push_back(i);
         if (live.size() != 0) op.job_id = job_ident[live[$urandom_range(live.size() - 1)]];
      end
      pick = $urandom_range(99);
      op.job_size = 17'($urandom_range(1, int'(cap)));
      if (pick < 5) op.job_size = 17'd0;
      else if (pick < 12) op.job_size = 17'($urandom);
      pick = $urandom_range(99);
      op.job_duration = 16'($urandom_range(1, 60));
      if (pick < 4) op.job_duration = 16'd0;
      else if (pick < 12) op.job_duration = 16'($urandom);
      pick = $urandom_range(99);
      op.time_step = 16'($urandom_range(0, 25));
      if (pick < 8) op.time_step = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 42)      op.func = bfra_pkg::FuncAlloc;
      else if (pick < 62) op.func = bfra_pkg::FuncRelease;
      else if (pick < 77) op.func = bfra_pkg::FuncTick;
      else if (pick < 84) op.func = bfra_pkg::FuncCompact;
      else if (pick < 97) op.func = bfra_pkg::FuncQuery;
      else                op.func = 3'($urandom_range(5, 7));
      return op;
   endfunction

   task automatic run_random(input int count, input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_stall_pct = rx_pct;
      for (int i = 0; i < count; i++) send_op(random_op());
   endtask

   // extremes, every operation and the corner cases of each
   task automatic test_directed_ops();
      send_fields(bfra_pkg::FuncQuery, 16'd0, 17'd0, 16'd1, 16'd0);
      send_fields(bfra_pkg::FuncAlloc, 16'hFFFF, 17'd65536, 16'hFFFF, 16'd0);
      send_fields(bfra_pkg::FuncAlloc, 16'd1, 17'd1, 16'd5, 16'd0);
      send_fields(bfra_pkg::FuncAlloc, 16'hFFFF, 17'd4, 16'd5, 16'd0);
      send_fields(bfra_pkg::FuncRelease, 16'd7, 17'd0, 16'd0, 16'd0);
      send_fields(bfra_pkg::FuncTick, 16'd0, 17'd0, 16'd0, 16'hFFFF);
      send_fields(bfra_pkg::FuncAlloc, 16'd0, 17'd0, 16'd9, 16'd0);
      send_fields(bfra_pkg::FuncAlloc, 16'd2, 17'h1FFFF, 16'd9, 16'd0);
      send_fields(bfra_pkg::FuncAlloc, 16'd3, 17'd10, 16'd0, 16'd0);
      send_fields(bfra_pkg::FuncTick, 16'd0, 17'd0, 16'd0, 16'd0);
      send_fields(3'd5, 16'hAAAA, 17'h15555, 16'h5555, 16'hAAAA);
      send_fields(3'd6, 16'd0, 17'd0, 16'd0, 16'd0);
      send_fields(3'd7, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF);
      send_fields(bfra_pkg::FuncAlloc, 16'd4, 17'd100, 16'd50, 16'd0);
      send_fields(bfra_pkg::FuncAlloc, 16'd5, 17'd50, 16'd50, 16'd0);
      send_fields(bfra_pkg::FuncAlloc, 16'd6, 17'd30, 16'd50, 16'd0);
      send_fields(bfra_pkg::FuncRelease, 16'd4, 17'd0, 16'd0, 16'd0);
      send_fields(bfra_pkg::FuncQuery, 16'd0, 17'd0, 16'd0, 16'd0);
      send_fields(bfra_pkg::FuncAlloc, 16'd7, 17'd20, 16'd50, 16'd0);
      send_fields(bfra_pkg::FuncCompact, 16'd0, 17'd0, 16'd0, 16'd0);
      send_fields(bfra_pkg::FuncQuery, 16'd0, 17'd1, 16'd0, 16'd0);
      send_fields(bfra_pkg::FuncTick, 16'd0, 17'd0, 16'd0, 16'd50);
   endtask

   // full table, then a shrink that leaves jobs beyond the new size
   task automatic test_table_full_and_shrink();
      write_mem_size(17'd64);
      for (int i = 0; i < NumJobs; i++)
         send_fields(bfra_pkg::FuncAlloc, 16'(100 + i), 17'(1 + i % 3), 16'(10 + i), 16'd0);
      send_fields(bfra_pkg::FuncAlloc, 16'd200, 17'd1, 16'd10, 16'd0);
      write_mem_size(17'd8);
      send_fields(bfra_pkg::FuncQuery, 16'd0, 17'd0, 16'd0, 16'd0);
      send_fields(bfra_pkg::FuncCompact, 16'd0, 17'd0, 16'd0, 16'd0);
      send_fields(bfra_pkg::FuncTick, 16'd0, 17'd0, 16'd0, 16'd12);
      send_fields(bfra_pkg::FuncAlloc, 16'd201, 17'd2, 16'd5, 16'd0);
      send_fields(bfra_pkg::FuncTick, 16'd0, 17'd0, 16'd0, 16'hFFFF);
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      hold_req = 1'b1;
      for (int i = 0; i < 30; i++) send_op(random_op());
   endtask

   task automatic test_random_traffic();
      write_mem_size(17'd65536);
      run_random(250, 0, 0);
      write_mem_size(17'd200);
      run_random(250, 84, 0);
      write_mem_size(17'd1);
      run_random(60, 0, 84);
      write_mem_size(17'd0);
      run_random(40, 31, 31);
      write_mem_size(17'h1FFFF);
      run_random(250, 0, 84);
      write_mem_size(17'd1000);
      run_random(250, 31, 31);
      write_mem_size(17'd37);
      run_random(250, 84, 84);
   endtask

   // response handshake with random stalls and requested hold-offs
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = HoldCycles;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      bfra_pkg::rsp_type seen;
      bfra_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.status         = rsp_chan.status;
         seen.placed_base    = rsp_chan.placed_base;
         seen.best_hole_size = rsp_chan.best_hole_size;
         seen.free_units     = rsp_chan.free_units;
         seen.finished_jobs  = rsp_chan.finished_jobs;
         seen.any_jobs       = rsp_chan.any_jobs;
         if (pending_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", seen);
         end else begin
            want = pending_rsp_q.pop_front();
            if (seen.status !== want.status || seen.placed_base !== want.placed_base ||
                seen.best_hole_size !== want.best_hole_size ||
                seen.free_units !== want.free_units ||
                seen.finished_jobs !== want.finished_jobs ||
                seen.any_jobs !== want.any_jobs) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected %p actual %p", want, seen);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // test sequence
   initial begin
      mismatches = 0;
      quiet_cycles = 0;
      hold_req = 1'b0;
      hold_left = 0;
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      reset_allocation_model();
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.func         <= bfra_pkg::FuncQuery;
      req_chan.job_id       <= '0;
      req_chan.job_size     <= '0;
      req_chan.job_duration <= '0;
      req_chan.time_step    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_ops();
      test_table_full_and_shrink();
      test_random_traffic();
      test_backpressure();
      drain();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
